>>> src/mecanum_wheel_speed_solver_assert.svh
// ----------------------------------------------------------------------------
// mecanum wheel speed solver assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_SOLVER_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_SOLVER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define MWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mws same-cycle check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define MWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mws next-cycle check failed");

`endif

>>> src/mws_pkg.sv
// ----------------------------------------------------------------------------
// mws_pkg
// types and constants of the mecanum wheel speed solver
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int unsigned WheelCount = 4;

  localparam int unsigned VelW   = 16;  // q4.12 commands
  localparam int unsigned RadW   = 16;  // q0.16 radii
  localparam int unsigned LimW   = 23;  // q11.12 limit magnitude
  localparam int unsigned SpeedW = 24;  // q12.12 signed wheel speed
  localparam int unsigned CfgW   = 23;  // widest register

  localparam int unsigned SumW   = 18;  // vx +/- vy +/- wr
  localparam int unsigned SMagW  = 17;  // |sum|
  localparam int unsigned UW     = 33;  // |sum| * 2^16 / R
  localparam int unsigned ProdW  = UW + LimW;  // |u| * limit

  localparam int unsigned RdivSteps = UW;    // one quotient bit per cell
  localparam int unsigned LdivSteps = LimW;  // scaled result stays below 2^23

  // register indexes of the configuration port
  localparam logic [1:0] CfgRotRadius = 2'd0;
  localparam logic [1:0] CfgWheelRadius = 2'd1;
  localparam logic [1:0] CfgMaxSpeed = 2'd2;

  localparam logic [RadW-1:0] RotRadiusRst   = 16'd19661;
  localparam logic [RadW-1:0] WheelRadiusRst = 16'd4981;
  localparam logic [LimW-1:0] MaxSpeedRst    = 23'd2048000;

  typedef struct packed {
    logic signed [VelW-1:0] surge_vel;
    logic signed [VelW-1:0] sway_vel;
    logic signed [VelW-1:0] yaw_rate;
  } in_beat_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] wheel_speed_0;
    logic signed [SpeedW-1:0] wheel_speed_1;
    logic signed [SpeedW-1:0] wheel_speed_2;
    logic signed [SpeedW-1:0] wheel_speed_3;
    logic                     was_scaled;
  } out_beat_t;

  // divide by wheel radius: quotient bits shift into the low end of acc
  typedef struct packed {
    logic            neg;
    logic [RadW-1:0] rem;
    logic [UW-1:0]   acc;
  } rdiv_t;

  // divide by peak: scaled magnitude builds up in acc
  typedef struct packed {
    logic            neg;
    logic            scl;
    logic [LimW-1:0] raw;
    logic [UW-1:0]   peak;
    logic [UW-1:0]   rem;
    logic [LimW-1:0] acc;
  } ldiv_t;

endpackage

>>> src/mws_rdiv_cell.sv
// ----------------------------------------------------------------------------
// mws_rdiv_cell
// one restoring step of the division by the wheel radius
// ----------------------------------------------------------------------------
module mws_rdiv_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [mws_pkg::RadW-1:0]     rden_i,
  input  mws_pkg::rdiv_t               d_i,
  output mws_pkg::rdiv_t               q_o
);

  logic [mws_pkg::RadW:0] trial;
  logic                   ge;
  mws_pkg::rdiv_t         step_d;
  mws_pkg::rdiv_t         step_q;

  always_comb begin
    trial        = {d_i.rem, d_i.acc[mws_pkg::UW-1]};
    ge           = trial >= {1'b0, rden_i};
    step_d.neg   = d_i.neg;
    step_d.rem   = ge ? mws_pkg::RadW'(trial - {1'b0, rden_i})
                      : trial[mws_pkg::RadW-1:0];
    step_d.acc   = {d_i.acc[mws_pkg::UW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

>>> src/mws_ldiv_cell.sv
// ----------------------------------------------------------------------------
// mws_ldiv_cell
// one restoring step of the division by the peak wheel magnitude
// ----------------------------------------------------------------------------
module mws_ldiv_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  mws_pkg::ldiv_t d_i,
  output mws_pkg::ldiv_t q_o
);

  logic [mws_pkg::UW:0] trial;
  logic                 ge;
  mws_pkg::ldiv_t       step_d;
  mws_pkg::ldiv_t       step_q;

  always_comb begin
    trial       = {d_i.rem, d_i.acc[mws_pkg::LimW-1]};
    ge          = trial >= {1'b0, d_i.peak};
    step_d      = d_i;
    step_d.rem  = ge ? mws_pkg::UW'(trial - {1'b0, d_i.peak})
                     : trial[mws_pkg::UW-1:0];
    step_d.acc  = {d_i.acc[mws_pkg::LimW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

>>> src/mecanum_wheel_speed_solver.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_solver
// mecanum inverse kinematics with desaturation, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input channel : in_valid_i / in_ready_o carry one velocity command beat
//   output channel: out_valid_o / out_ready_i carry four wheel speeds and
//                   the was_scaled flag, one result beat per command beat
//   config port   : cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//                   (0 rotation radius, 1 wheel radius, 2 speed limit);
//                   write only while the pipe is empty
//   latency       : 61 cycles from the accepting edge to out_valid_o
//   throughput    : one beat per cycle; set by the one-bit-per-cell chains,
//                   33 cells dividing by the wheel radius and 23 cells
//                   dividing by the peak magnitude, all stepping together
//   reset         : pipe emptied, registers back to their defaults
//   stall         : the whole pipe holds while out_ready_i is low and a
//                   result waits; in_ready_o then drops, nothing is lost
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_solver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  mws_pkg::in_beat_t          in_beat_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mws_pkg::out_beat_t         out_beat_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [mws_pkg::CfgW-1:0]   cfg_wdata_i
);

  localparam int unsigned NumStages = 3 + mws_pkg::RdivSteps + 3 + mws_pkg::LdivSteps - 1;

  // configuration registers
  logic [mws_pkg::RadW-1:0] rot_radius_q;
  logic [mws_pkg::RadW-1:0] wheel_radius_q;
  logic [mws_pkg::LimW-1:0] max_speed_q;
  logic [mws_pkg::RadW-1:0] rden;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_radius_q   <= mws_pkg::RotRadiusRst;
      wheel_radius_q <= mws_pkg::WheelRadiusRst;
      max_speed_q    <= mws_pkg::MaxSpeedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mws_pkg::CfgRotRadius:   rot_radius_q   <= cfg_wdata_i[mws_pkg::RadW-1:0];
        mws_pkg::CfgWheelRadius: wheel_radius_q <= cfg_wdata_i[mws_pkg::RadW-1:0];
        mws_pkg::CfgMaxSpeed:    max_speed_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero wheel radius acts as the smallest step
  assign rden = (wheel_radius_q == '0) ? mws_pkg::RadW'(1) : wheel_radius_q;

  // global advance: the pipe moves unless a finished beat is waiting
  logic                 en;
  logic [NumStages-1:0] vld_q;
  logic                 out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NumStages-2:0], in_valid_i && in_ready_o};
      out_valid_q <= vld_q[NumStages-1];
    end
  end

  assign out_valid_o = out_valid_q;

  // stage a: yaw term w*r, truncated toward zero
  logic                          w_neg;
  logic [mws_pkg::VelW:0]        w_mag;
  logic [2*mws_pkg::RadW:0]      wr_prod;
  logic [mws_pkg::SumW-1:0]      wr_ext;
  logic signed [mws_pkg::SumW-1:0] wr_d, wr_a_q;
  logic signed [mws_pkg::VelW-1:0] vx_a_q, vy_a_q;

  always_comb begin
    w_neg   = in_beat_i.yaw_rate[mws_pkg::VelW-1];
    w_mag   = w_neg ? (mws_pkg::VelW+1)'(0 - {1'b1, in_beat_i.yaw_rate})
                    : {1'b0, in_beat_i.yaw_rate};
    wr_prod = w_mag * rot_radius_q;
    wr_ext  = {1'b0, wr_prod[2*mws_pkg::RadW:mws_pkg::RadW]};
    wr_d    = w_neg ? $signed(mws_pkg::SumW'(0 - wr_ext)) : $signed(wr_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_a_q <= in_beat_i.surge_vel;
      vy_a_q <= in_beat_i.sway_vel;
      wr_a_q <= wr_d;
    end
  end

  // stage b: the four wheel sums, split into sign and magnitude
  logic signed [mws_pkg::SumW-1:0] vx_e, vy_e;
  logic signed [mws_pkg::SumW-1:0] sum [mws_pkg::WheelCount];
  mws_pkg::rdiv_t                  rd [mws_pkg::WheelCount][mws_pkg::RdivSteps+1];
  mws_pkg::rdiv_t                  rd_b_d [mws_pkg::WheelCount];

  always_comb begin
    vx_e   = mws_pkg::SumW'(vx_a_q);
    vy_e   = mws_pkg::SumW'(vy_a_q);
    sum[0] = vx_e + vy_e + wr_a_q;
    sum[1] = vx_e - vy_e - wr_a_q;
    sum[2] = vx_e + vy_e - wr_a_q;
    sum[3] = vx_e - vy_e + wr_a_q;
    for (int l = 0; l < mws_pkg::WheelCount; l++) begin
      rd_b_d[l].neg = sum[l][mws_pkg::SumW-1];
      rd_b_d[l].rem = '0;
      rd_b_d[l].acc = {(sum[l][mws_pkg::SumW-1] ? mws_pkg::SMagW'(0 - sum[l])
                                                 : sum[l][mws_pkg::SMagW-1:0]),
                       {mws_pkg::RadW{1'b0}}};
    end
  end

  // division by the wheel radius: a row of cells per wheel
  for (genvar l = 0; l < mws_pkg::WheelCount; l++) begin : g_rlane
    always_ff @(posedge clk_i) begin
      if (en) begin
        rd[l][0] <= rd_b_d[l];
      end
    end
    for (genvar k = 0; k < mws_pkg::RdivSteps; k++) begin : g_rcell
      mws_rdiv_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rden_i (rden),
        .d_i    (rd[l][k]),
        .q_o    (rd[l][k+1])
      );
    end
  end

  // peak magnitude over two stages, with the limit compare in the second
  logic [mws_pkg::UW-1:0] u_p1_q [mws_pkg::WheelCount];
  logic                   neg_p1_q [mws_pkg::WheelCount];
  logic [mws_pkg::UW-1:0] m01_q, m23_q;
  logic [mws_pkg::UW-1:0] u_p2_q [mws_pkg::WheelCount];
  logic                   neg_p2_q [mws_pkg::WheelCount];
  logic [mws_pkg::UW-1:0] peak_q;
  logic                   scl_q;
  logic [mws_pkg::UW-1:0] peak_d;

  assign peak_d = (m01_q > m23_q) ? m01_q : m23_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < mws_pkg::WheelCount; l++) begin
        u_p1_q[l]   <= rd[l][mws_pkg::RdivSteps].acc;
        neg_p1_q[l] <= rd[l][mws_pkg::RdivSteps].neg;
        u_p2_q[l]   <= u_p1_q[l];
        neg_p2_q[l] <= neg_p1_q[l];
      end
      m01_q  <= (rd[0][mws_pkg::RdivSteps].acc > rd[1][mws_pkg::RdivSteps].acc)
                ? rd[0][mws_pkg::RdivSteps].acc : rd[1][mws_pkg::RdivSteps].acc;
      m23_q  <= (rd[2][mws_pkg::RdivSteps].acc > rd[3][mws_pkg::RdivSteps].acc)
                ? rd[2][mws_pkg::RdivSteps].acc : rd[3][mws_pkg::RdivSteps].acc;
      peak_q <= peak_d;
      scl_q  <= peak_d > {{(mws_pkg::UW-mws_pkg::LimW){1'b0}}, max_speed_q};
    end
  end

  // |u| * limit, then the division by the peak in a row of cells
  mws_pkg::ldiv_t ld [mws_pkg::WheelCount][mws_pkg::LdivSteps+1];

  for (genvar l = 0; l < mws_pkg::WheelCount; l++) begin : g_llane
    logic [mws_pkg::ProdW-1:0] prod;
    assign prod = u_p2_q[l] * max_speed_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        ld[l][0].neg  <= neg_p2_q[l];
        ld[l][0].scl  <= scl_q;
        ld[l][0].raw  <= u_p2_q[l][mws_pkg::LimW-1:0];  // at or below the limit when unscaled
        ld[l][0].peak <= peak_q;
        ld[l][0].rem  <= prod[mws_pkg::ProdW-1:mws_pkg::LimW];
        ld[l][0].acc  <= prod[mws_pkg::LimW-1:0];
      end
    end
    for (genvar k = 0; k < mws_pkg::LdivSteps; k++) begin : g_lcell
      mws_ldiv_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (ld[l][k]),
        .q_o   (ld[l][k+1])
      );
    end
  end

  // output register: pick scaled or raw magnitude and restore the sign
  logic [mws_pkg::SpeedW-1:0] spd [mws_pkg::WheelCount];
  mws_pkg::out_beat_t         out_d, out_q;

  always_comb begin
    for (int l = 0; l < mws_pkg::WheelCount; l++) begin
      spd[l] = {1'b0, ld[l][mws_pkg::LdivSteps].scl ? ld[l][mws_pkg::LdivSteps].acc
                                                    : ld[l][mws_pkg::LdivSteps].raw};
      if (ld[l][mws_pkg::LdivSteps].neg) begin
        spd[l] = mws_pkg::SpeedW'(0 - spd[l]);
      end
    end
    out_d.wheel_speed_0 = $signed(spd[0]);
    out_d.wheel_speed_1 = $signed(spd[1]);
    out_d.wheel_speed_2 = $signed(spd[2]);
    out_d.wheel_speed_3 = $signed(spd[3]);
    out_d.was_scaled    = ld[0][mws_pkg::LdivSteps].scl;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_beat_o = out_q;

endmodule

>>> src/mws_checker.sv
// ----------------------------------------------------------------------------
// mws_checker
// port-level checks of the solver, bound to the top level
// ----------------------------------------------------------------------------
`include "mecanum_wheel_speed_solver_assert.svh"

module mws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mws_pkg::out_beat_t out_beat_o
);

  // a waiting result beat stays
  `MWS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  // and keeps its payload
  `MWS_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_beat_o))
  // an empty output stage never blocks the input
  `MWS_ASSERT_IMPL(a_in_open_empty, !out_valid_o, in_ready_o)
  // a taken result frees the input in the same cycle
  `MWS_ASSERT_IMPL(a_in_open_taken, out_ready_i, in_ready_o)

endmodule

bind mecanum_wheel_speed_solver mws_checker u_mws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);
